// File: rtl/fastq_fasta_record_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FASTQ/FASTA record parser
// Each macro checks one property on clk with reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef FASTQ_FASTA_RECORD_PARSER_CORE_MACROS_SVH
`define FASTQ_FASTA_RECORD_PARSER_CORE_MACROS_SVH

// Same-cycle implication
`define FQFA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqfa: same-cycle check failed");

// Next-cycle implication
`define FQFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqfa: next-cycle check failed");

`endif

// File: rtl/fqfa_pkg.sv
// ----------------------------------------------------------------------------
// fqfa_pkg
// Shared types, constants and helpers of the FASTQ/FASTA record parser.
// ----------------------------------------------------------------------------
package fqfa_pkg;

    // Field widths
    localparam int SEQ_W = 16;
    localparam int REC_W = 32;
    localparam int OFF_W = 48;

    // Saturation limits
    localparam logic [SEQ_W-1:0] MAX_SEQ_LEN = 16'hFFFF;
    localparam logic [REC_W-1:0] REC_MAX     = '1;
    localparam logic [OFF_W-1:0] OFF_MAX     = '1;

    // Characters of interest
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    // Quality class thresholds
    localparam logic [7:0] QUAL_SANGER_LIM = 8'd59;
    localparam logic [7:0] QUAL_SOLEXA_LIM = 8'd74;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_ID    = 3'd1,
        PH_SEQ   = 3'd2,
        PH_COM   = 3'd3,
        PH_QUAL  = 3'd4,
        PH_FBODY = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_EOF = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_LEN     = 3'd1,
        ERR_TAG     = 3'd2,
        ERR_COMMENT = 3'd3,
        ERR_EMPTY   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        QC_UNKNOWN = 2'd0,
        QC_SANGER  = 2'd1,
        QC_SOLEXA  = 2'd2
    } qclass_t;

    typedef struct packed {
        status_t           status;
        err_t              error_kind;
        logic              is_fasta;
        logic [SEQ_W-1:0]  seq_length;
        logic [REC_W-1:0]  record_number;
        logic [OFF_W-1:0]  byte_offset;
        qclass_t           quality_class;
        logic              last_result;
    } result_t;

    // Up to two results per accepted beat
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [SEQ_W-1:0] sat_inc(input logic [SEQ_W-1:0] c);
        sat_inc = (c != MAX_SEQ_LEN) ? c + 1'b1 : c;
    endfunction

    function automatic logic [SEQ_W-1:0] strip_cr(input logic [SEQ_W-1:0] c,
                                                  input logic cr);
        strip_cr = (cr && (c != '0) && (c != MAX_SEQ_LEN)) ? c - 1'b1 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// File: rtl/fastq_fasta_record_parser_core.sv
// A result is registered in the result queue by the beat that closes its record.
// Throughput: one byte per cycle while in_ready is high; the parse state updates
// in the accepting cycle. A byte that yields two results sends them out in turn;
// the four-entry result queue absorbs this, and input ready drops once it holds
// three or more. Reset (rst_n, async, active low) restarts parsing at a record tag,
// clears all counts and empties the result queue.
// ----------------------------------------------------------------------------
// fastq_fasta_record_parser_core
// Byte-serial FASTQ/FASTA record parser with per-record status results.
// ----------------------------------------------------------------------------
`include "fastq_fasta_record_parser_core_macros.svh"

module fastq_fasta_record_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         end_of_file,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [2:0]   error_kind,
    output logic         is_fasta,
    output logic [15:0]  seq_length,
    output logic [31:0]  record_number,
    output logic [47:0]  byte_offset,
    output logic [1:0]   quality_class,
    output logic         last_result
);

    logic                               fire;
    logic                               pop;
    fqfa_pkg::push_t                    push;
    fqfa_pkg::result_t                  head;
    logic [fqfa_pkg::QLVL_W-1:0]        level;

    // Accept while two slots are free
    assign in_ready = (level <= fqfa_pkg::QLVL_W'(fqfa_pkg::QDEPTH - 2));
    assign fire     = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    fqfa_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .push        (push)
    );

    fqfa_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (out_valid),
        .level      (level)
    );

    // Drive result fields from the queue head
    assign status        = head.status;
    assign error_kind    = head.error_kind;
    assign is_fasta      = head.is_fasta;
    assign seq_length    = head.seq_length;
    assign record_number = head.record_number;
    assign byte_offset   = head.byte_offset;
    assign quality_class = head.quality_class;
    assign last_result   = head.last_result;

    `FQFA_ASSERT_IMPLY(a_level_bound, 1'b1, level <= fqfa_pkg::QLVL_W'(fqfa_pkg::QDEPTH))
    `FQFA_ASSERT_NEXT(a_eof_gives_result, fire && end_of_file, out_valid)
    `FQFA_ASSERT_IMPLY(a_eof_is_last, out_valid && (status == fqfa_pkg::ST_EOF), last_result)
    `FQFA_ASSERT_IMPLY(a_no_overfill, push.cnt == 2'd2, level <= fqfa_pkg::QLVL_W'(fqfa_pkg::QDEPTH - 2))

endmodule

// File: rtl/fqfa_parser.sv
// ----------------------------------------------------------------------------
// fqfa_parser
// Record state machine: updates the parse state on each accepted beat and
// builds the zero, one or two results that the beat produces.
// ----------------------------------------------------------------------------
module fqfa_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    input  logic                end_of_file,
    output fqfa_pkg::push_t     push
);

    fqfa_pkg::phase_t                   phase_reg, phase_next;
    logic [7:0]                         tag_reg, tag_next;
    logic [fqfa_pkg::SEQ_W-1:0]         seq_cnt_reg, seq_cnt_next;
    logic [fqfa_pkg::SEQ_W-1:0]         qual_cnt_reg, qual_cnt_next;
    logic                               line_start_reg, line_start_next;
    logic                               comment_ok_reg, comment_ok_next;
    logic                               last_cr_reg, last_cr_next;
    fqfa_pkg::qclass_t                  qclass_reg, qclass_next;
    logic [fqfa_pkg::REC_W-1:0]         rec_cnt_reg, rec_cnt_next;
    logic [fqfa_pkg::OFF_W-1:0]         byte_cnt_reg, byte_cnt_next;

    logic                               is_lf;
    logic                               is_cr;
    logic                               is_gt;
    logic [fqfa_pkg::SEQ_W-1:0]         qual_fin;
    logic [fqfa_pkg::REC_W-1:0]         rec_inc;
    logic [fqfa_pkg::OFF_W-1:0]         byte_inc;
    fqfa_pkg::err_t                     fq_err;
    fqfa_pkg::result_t                  fq_res;
    fqfa_pkg::result_t                  fa_res;
    fqfa_pkg::result_t                  tr_res;
    fqfa_pkg::result_t                  eof_res;
    logic                               eof_has_rec;

    // Decode the byte and the saturating counters
    assign is_lf    = (data_byte == fqfa_pkg::CH_LF);
    assign is_cr    = (data_byte == fqfa_pkg::CH_CR);
    assign is_gt    = (data_byte == fqfa_pkg::CH_GT);
    assign qual_fin = fqfa_pkg::strip_cr(qual_cnt_reg, last_cr_reg);
    assign rec_inc  = (rec_cnt_reg != fqfa_pkg::REC_MAX) ? rec_cnt_reg + 1'b1 : rec_cnt_reg;
    assign byte_inc = (byte_cnt_reg != fqfa_pkg::OFF_MAX) ? byte_cnt_reg + 1'b1
                                                          : byte_cnt_reg;
    assign eof_has_rec = (phase_reg != fqfa_pkg::PH_TAG);

    // Rank FASTQ errors: length, then tag, then comment
    always_comb
    begin
        if (seq_cnt_reg != qual_fin)
            fq_err = fqfa_pkg::ERR_LEN;
        else if (tag_reg != fqfa_pkg::CH_AT)
            fq_err = fqfa_pkg::ERR_TAG;
        else if (!comment_ok_reg)
            fq_err = fqfa_pkg::ERR_COMMENT;
        else
            fq_err = fqfa_pkg::ERR_NONE;
    end

    // Build the record results; number and offset filled in per case
    always_comb
    begin
        fq_res               = '0;
        fq_res.status        = (fq_err != fqfa_pkg::ERR_NONE) ? fqfa_pkg::ST_BAD
                                                              : fqfa_pkg::ST_OK;
        fq_res.error_kind    = fq_err;
        fq_res.is_fasta      = 1'b0;
        fq_res.seq_length    = seq_cnt_reg;
        fq_res.quality_class = (fq_err != fqfa_pkg::ERR_NONE) ? fqfa_pkg::QC_UNKNOWN
                                                              : qclass_reg;

        fa_res               = '0;
        fa_res.is_fasta      = 1'b1;
        fa_res.quality_class = fqfa_pkg::QC_UNKNOWN;
        if (seq_cnt_reg == '0)
        begin
            fa_res.status     = fqfa_pkg::ST_BAD;
            fa_res.error_kind = fqfa_pkg::ERR_EMPTY;
            fa_res.seq_length = '0;
        end
        else
        begin
            fa_res.status     = fqfa_pkg::ST_OK;
            fa_res.error_kind = fqfa_pkg::ERR_NONE;
            fa_res.seq_length = seq_cnt_reg;
        end

        tr_res               = '0;
        tr_res.status        = fqfa_pkg::ST_BAD;
        tr_res.error_kind    = fqfa_pkg::ERR_EMPTY;
        tr_res.is_fasta      = (tag_reg == fqfa_pkg::CH_GT);
        tr_res.quality_class = fqfa_pkg::QC_UNKNOWN;

        eof_res               = '0;
        eof_res.status        = fqfa_pkg::ST_EOF;
        eof_res.error_kind    = fqfa_pkg::ERR_NONE;
        eof_res.quality_class = fqfa_pkg::QC_UNKNOWN;
        eof_res.record_number = eof_has_rec ? rec_inc : rec_cnt_reg;
        eof_res.byte_offset   = byte_cnt_reg;
        eof_res.last_result   = 1'b1;
    end

    // Outputs: pick the results this beat produces
    always_comb
    begin
        push     = '0;
        push.r0  = eof_res;
        push.r1  = eof_res;
        if (fire && end_of_file)
        begin
            if (eof_has_rec)
            begin
                push.cnt = 2'd2;
                if (phase_reg == fqfa_pkg::PH_FBODY)
                    push.r0 = fa_res;
                else if ((phase_reg == fqfa_pkg::PH_QUAL) && !line_start_reg)
                    push.r0 = fq_res;
                else
                    push.r0 = tr_res;
                push.r0.record_number = rec_inc;
                push.r0.byte_offset   = byte_cnt_reg;
                push.r0.last_result   = 1'b0;
            end
            else
            begin
                push.cnt = 2'd1;
            end
        end
        else if (fire && (phase_reg == fqfa_pkg::PH_FBODY) && is_gt)
        begin
            // The '>' closes the record and is not part of its offset
            push.cnt              = 2'd1;
            push.r0               = fa_res;
            push.r0.record_number = rec_inc;
            push.r0.byte_offset   = byte_cnt_reg;
            push.r0.last_result   = 1'b1;
        end
        else if (fire && (phase_reg == fqfa_pkg::PH_QUAL) && is_lf)
        begin
            push.cnt              = 2'd1;
            push.r0               = fq_res;
            push.r0.record_number = rec_inc;
            push.r0.byte_offset   = byte_inc;
            push.r0.last_result   = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        tag_next        = tag_reg;
        seq_cnt_next    = seq_cnt_reg;
        qual_cnt_next   = qual_cnt_reg;
        line_start_next = line_start_reg;
        comment_ok_next = comment_ok_reg;
        last_cr_next    = last_cr_reg;
        qclass_next     = qclass_reg;
        rec_cnt_next    = rec_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;

        if (fire && end_of_file)
        begin
            // Close any open record and restart, keeping the counts
            if (eof_has_rec)
                rec_cnt_next = rec_inc;
            phase_next      = fqfa_pkg::PH_TAG;
            line_start_next = 1'b1;
            last_cr_next    = 1'b0;
        end
        else if (fire)
        begin
            byte_cnt_next = byte_inc;
            unique case (phase_reg)
                fqfa_pkg::PH_TAG, fqfa_pkg::PH_FBODY:
                begin
                    if ((phase_reg == fqfa_pkg::PH_TAG) || is_gt)
                    begin
                        if (phase_reg == fqfa_pkg::PH_FBODY)
                            rec_cnt_next = rec_inc;
                        tag_next        = data_byte;
                        seq_cnt_next    = '0;
                        qual_cnt_next   = '0;
                        comment_ok_next = 1'b0;
                        last_cr_next    = 1'b0;
                        qclass_next     = fqfa_pkg::QC_UNKNOWN;
                        line_start_next = 1'b1;
                        phase_next      = fqfa_pkg::PH_ID;
                    end
                    else if (!fqfa_pkg::is_space(data_byte))
                    begin
                        seq_cnt_next = fqfa_pkg::sat_inc(seq_cnt_reg);
                    end
                end
                fqfa_pkg::PH_ID:
                begin
                    if (is_lf)
                        phase_next = (tag_reg == fqfa_pkg::CH_GT) ? fqfa_pkg::PH_FBODY
                                                                  : fqfa_pkg::PH_SEQ;
                end
                fqfa_pkg::PH_SEQ:
                begin
                    if (is_lf)
                    begin
                        seq_cnt_next    = fqfa_pkg::strip_cr(seq_cnt_reg, last_cr_reg);
                        last_cr_next    = 1'b0;
                        line_start_next = 1'b1;
                        phase_next      = fqfa_pkg::PH_COM;
                    end
                    else
                    begin
                        seq_cnt_next = fqfa_pkg::sat_inc(seq_cnt_reg);
                        last_cr_next = is_cr;
                    end
                end
                fqfa_pkg::PH_COM:
                begin
                    if (line_start_reg)
                    begin
                        comment_ok_next = (data_byte == fqfa_pkg::CH_PLUS);
                        line_start_next = 1'b0;
                    end
                    if (is_lf)
                    begin
                        line_start_next = 1'b1;
                        last_cr_next    = 1'b0;
                        phase_next      = fqfa_pkg::PH_QUAL;
                    end
                end
                fqfa_pkg::PH_QUAL:
                begin
                    if (is_lf)
                    begin
                        line_start_next = 1'b1;
                        last_cr_next    = 1'b0;
                        qual_cnt_next   = qual_fin;
                        rec_cnt_next    = rec_inc;
                        phase_next      = fqfa_pkg::PH_TAG;
                    end
                    else
                    begin
                        line_start_next = 1'b0;
                        qual_cnt_next   = fqfa_pkg::sat_inc(qual_cnt_reg);
                        last_cr_next    = is_cr;
                        // First decisive non-CR byte sets the class
                        if ((qclass_reg == fqfa_pkg::QC_UNKNOWN) && !is_cr)
                        begin
                            if (data_byte < fqfa_pkg::QUAL_SANGER_LIM)
                                qclass_next = fqfa_pkg::QC_SANGER;
                            else if (data_byte > fqfa_pkg::QUAL_SOLEXA_LIM)
                                qclass_next = fqfa_pkg::QC_SOLEXA;
                        end
                    end
                end
                default:
                begin
                    phase_next = fqfa_pkg::PH_TAG;
                end
            endcase
        end
    end

    // Hold the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fqfa_pkg::PH_TAG;
            tag_reg        <= '0;
            seq_cnt_reg    <= '0;
            qual_cnt_reg   <= '0;
            line_start_reg <= 1'b1;
            comment_ok_reg <= 1'b0;
            last_cr_reg    <= 1'b0;
            qclass_reg     <= fqfa_pkg::QC_UNKNOWN;
            rec_cnt_reg    <= '0;
            byte_cnt_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tag_reg        <= tag_next;
            seq_cnt_reg    <= seq_cnt_next;
            qual_cnt_reg   <= qual_cnt_next;
            line_start_reg <= line_start_next;
            comment_ok_reg <= comment_ok_next;
            last_cr_reg    <= last_cr_next;
            qclass_reg     <= qclass_next;
            rec_cnt_reg    <= rec_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
        end
    end

endmodule

// File: rtl/fqfa_result_queue.sv
// ----------------------------------------------------------------------------
// fqfa_result_queue
// Small result FIFO: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module fqfa_result_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fqfa_pkg::push_t              push,
    input  logic                         pop,
    output fqfa_pkg::result_t            head,
    output logic                         head_valid,
    output logic [fqfa_pkg::QLVL_W-1:0]  level
);

    fqfa_pkg::result_t                  mem [fqfa_pkg::QDEPTH];
    logic [fqfa_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [fqfa_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [fqfa_pkg::QLVL_W-1:0]        level_reg, level_next;
    logic [fqfa_pkg::QPTR_W-1:0]        wr_ptr_p1;

    assign wr_ptr_p1  = wr_ptr_reg + 1'b1;
    assign head       = mem[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + fqfa_pkg::QPTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + fqfa_pkg::QPTR_W'(pop);
        level_next  = level_reg + fqfa_pkg::QLVL_W'(push.cnt) - fqfa_pkg::QLVL_W'(pop);
    end

    // Write results in order
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem[wr_ptr_p1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the FASTQ/FASTA record parser
// Streams byte beats into the parser: a short directed set, then random
// FASTQ, FASTA, truncated and noise records. A scoreboard predicts each
// record result from the accepted beats and checks every result beat in
// order, field by field.
// ----------------------------------------------------------------------------
import fqfa_pkg::*;

class record_scoreboard;
    phase_t      ph;
    logic [7:0]  tag;
    logic [15:0] seq_n;
    logic [15:0] qual_n;
    logic        line_start;
    logic        comment_ok;
    logic        last_cr;
    qclass_t     qcls;
    logic [31:0] rec_n;
    logic [47:0] bytes_n;
    result_t     want_q[$];
    int          errors;

    function new();
        ph         = PH_TAG;
        tag        = '0;
        seq_n      = '0;
        qual_n     = '0;
        line_start = 1'b1;
        comment_ok = 1'b0;
        last_cr    = 1'b0;
        qcls       = QC_UNKNOWN;
        rec_n      = '0;
        bytes_n    = '0;
        errors     = 0;
    endfunction

    // Saturating length step
    function logic [15:0] bump(logic [15:0] c);
        return (c == MAX_SEQ_LEN) ? c : c + 16'd1;
    endfunction

    // Remove one trailing CR unless the count is empty or saturated
    function logic [15:0] drop_cr(logic [15:0] c, logic cr);
        return (cr && c != '0 && c != MAX_SEQ_LEN) ? c - 16'd1 : c;
    endfunction

    function bit blank(logic [7:0] b);
        return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void count_record();
        if (rec_n != REC_MAX)
            rec_n++;
    endfunction

    function void queue_result(status_t st, err_t ek, logic fa, logic [15:0] len,
                               qclass_t qc, logic last);
        result_t r;
        r.status        = st;
        r.error_kind    = ek;
        r.is_fasta      = fa;
        r.seq_length    = len;
        r.record_number = rec_n;
        r.byte_offset   = bytes_n;
        r.quality_class = qc;
        r.last_result   = last;
        want_q.push_back(r);
    endfunction

    // Close a FASTQ record: length mismatch wins over tag, tag over comment
    function void close_fastq(logic last);
        err_t ek;
        qual_n  = drop_cr(qual_n, last_cr);
        last_cr = 1'b0;
        count_record();
        if (seq_n != qual_n)
            ek = ERR_LEN;
        else if (tag != CH_AT)
            ek = ERR_TAG;
        else if (!comment_ok)
            ek = ERR_COMMENT;
        else
            ek = ERR_NONE;
        if (ek == ERR_NONE)
            queue_result(ST_OK, ERR_NONE, 1'b0, seq_n, qcls, last);
        else
            queue_result(ST_BAD, ek, 1'b0, seq_n, QC_UNKNOWN, last);
        ph = PH_TAG;
    endfunction

    function void close_fasta(logic last);
        count_record();
        if (seq_n == '0)
            queue_result(ST_BAD, ERR_EMPTY, 1'b1, '0, QC_UNKNOWN, last);
        else
            queue_result(ST_OK, ERR_NONE, 1'b1, seq_n, QC_UNKNOWN, last);
        ph = PH_TAG;
    endfunction

    function void open_record(logic [7:0] b);
        tag        = b;
        seq_n      = '0;
        qual_n     = '0;
        comment_ok = 1'b0;
        last_cr    = 1'b0;
        qcls       = QC_UNKNOWN;
        line_start = 1'b1;
        ph         = PH_ID;
    endfunction

    // Advance the parse by one accepted input beat
    function void note_beat(logic [7:0] b, logic eof);
        if (eof) begin
            if (ph == PH_FBODY) begin
                close_fasta(1'b0);
            end
            else if (ph == PH_QUAL && !line_start) begin
                close_fastq(1'b0);
            end
            else if (ph != PH_TAG) begin
                count_record();
                queue_result(ST_BAD, ERR_EMPTY, tag == CH_GT, '0, QC_UNKNOWN, 1'b0);
            end
            queue_result(ST_EOF, ERR_NONE, 1'b0, '0, QC_UNKNOWN, 1'b1);
            ph         = PH_TAG;
            line_start = 1'b1;
            last_cr    = 1'b0;
        end
        else begin
            // A '>' closes the FASTA record before it is counted
            if (ph == PH_FBODY && b == CH_GT)
                close_fasta(1'b1);
            if (bytes_n != OFF_MAX)
                bytes_n++;
            case (ph)
                PH_TAG, PH_FBODY:
                begin
                    if (ph == PH_TAG || b == CH_GT)
                        open_record(b);
                    else if (!blank(b))
                        seq_n = bump(seq_n);
                end
                PH_ID:
                begin
                    if (b == CH_LF)
                        ph = (tag == CH_GT) ? PH_FBODY : PH_SEQ;
                end
                PH_SEQ:
                begin
                    if (b == CH_LF) begin
                        seq_n      = drop_cr(seq_n, last_cr);
                        last_cr    = 1'b0;
                        line_start = 1'b1;
                        ph         = PH_COM;
                    end
                    else begin
                        seq_n   = bump(seq_n);
                        last_cr = (b == CH_CR);
                    end
                end
                PH_COM:
                begin
                    if (line_start) begin
                        comment_ok = (b == CH_PLUS);
                        line_start = 1'b0;
                    end
                    if (b == CH_LF) begin
                        line_start = 1'b1;
                        last_cr    = 1'b0;
                        ph         = PH_QUAL;
                    end
                end
                PH_QUAL:
                begin
                    if (b == CH_LF) begin
                        line_start = 1'b1;
                        close_fastq(1'b1);
                    end
                    else begin
                        line_start = 1'b0;
                        qual_n     = bump(qual_n);
                        last_cr    = (b == CH_CR);
                        // CR never decides the quality class
                        if (qcls == QC_UNKNOWN && b != CH_CR) begin
                            if (b < QUAL_SANGER_LIM)
                                qcls = QC_SANGER;
                            else if (b > QUAL_SOLEXA_LIM)
                                qcls = QC_SOLEXA;
                        end
                    end
                end
                default:
                begin
                    ph = PH_TAG;
                end
            endcase
        end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Check one result beat against the oldest predicted result
    function void check_result(result_t got);
        result_t want;
        if (want_q.size() == 0) begin
            $error("result beat with no result pending: status %0d record %0d",
                   got.status, got.record_number);
            errors++;
        end
        else begin
            want = want_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("error_kind", want.error_kind, got.error_kind);
            compare_field("is_fasta", want.is_fasta, got.is_fasta);
            compare_field("seq_length", want.seq_length, got.seq_length);
            compare_field("record_number", want.record_number, got.record_number);
            compare_field("byte_offset", want.byte_offset, got.byte_offset);
            compare_field("quality_class", want.quality_class, got.quality_class);
            compare_field("last_result", want.last_result, got.last_result);
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction
endclass

module tb_top;

    localparam int RANDOM_BEATS = 1350;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRESSURE_AT  = 600;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [2:0]  error_kind;
    logic        is_fasta;
    logic [15:0] seq_length;
    logic [31:0] record_number;
    logic [47:0] byte_offset;
    logic [1:0]  quality_class;
    logic        last_result;

    record_scoreboard sb = new();

    logic [8:0]  beat_q[$];
    int          sent_beats = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req   = 1'b0;
    int unsigned cycle_count = 0;

    fastq_fasta_record_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .error_kind    (error_kind),
        .is_fasta      (is_fasta),
        .seq_length    (seq_length),
        .record_number (record_number),
        .byte_offset   (byte_offset),
        .quality_class (quality_class),
        .last_result   (last_result)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Note input beats first, then check result beats
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_beat(data_byte, end_of_file);
            if (out_valid && out_ready)
                sb.check_result({status, error_kind, is_fasta, seq_length, record_number,
                                 byte_offset, quality_class, last_result});
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                               : $urandom_range(10, 50);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idle_on || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic eof);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_queued();
        logic [8:0] beat;
        while (beat_q.size() != 0) begin
            beat = beat_q.pop_front();
            send_beat(beat[7:0], beat[8]);
            sent_beats++;
        end
    endtask

    function automatic void put(logic [7:0] b);
        beat_q.push_back({1'b0, b});
    endfunction

    function automatic void put_eof();
        beat_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void put_line(string s, bit with_cr);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
        if (with_cr)
            put(CH_CR);
        put(CH_LF);
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] base_char();
        string alphabet = "ACGTNacgtn";
        return alphabet[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] qual_char();
        if ($urandom_range(0, 9) == 0)
            return any_but_lf();
        return 8'($urandom_range(33, 126));
    endfunction

    // Mostly well-formed FASTQ with random content and occasional defects
    function automatic void make_fastq();
        int         seq_len;
        int         qual_len;
        int         r;
        logic [7:0] t;
        t = CH_AT;
        if ($urandom_range(0, 99) >= 85) begin
            t = 8'($urandom_range(0, 255));
            while (t == CH_GT)
                t = 8'($urandom_range(0, 255));
        end
        put(t);
        repeat ($urandom_range(0, 6)) put(any_but_lf());
        put(CH_LF);
        seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (seq_len) put(($urandom_range(0, 19) == 0) ? any_but_lf() : base_char());
        if ($urandom_range(0, 4) == 0)
            put(CH_CR);
        put(CH_LF);
        r = $urandom_range(0, 99);
        if (r < 88) begin
            put(CH_PLUS);
            repeat ($urandom_range(0, 4)) put(any_but_lf());
        end
        else if (r < 95) begin
            t = any_but_lf();
            while (t == CH_PLUS)
                t = any_but_lf();
            put(t);
        end
        put(CH_LF);
        qual_len = seq_len;
        if ($urandom_range(0, 4) == 0)
            qual_len = seq_len + int'($urandom_range(0, 3)) - 1;
        if (qual_len < 0)
            qual_len = 0;
        // A leading CR takes one quality slot but never decides the class
        if (qual_len > 0 && $urandom_range(0, 9) == 0) begin
            put(CH_CR);
            qual_len--;
        end
        repeat (qual_len) put(qual_char());
        if ($urandom_range(0, 4) == 0)
            put(CH_CR);
        if ($urandom_range(0, 6) == 0)
            put_eof();
        else
            put(CH_LF);
    endfunction

    function automatic void make_fasta();
        put(CH_GT);
        repeat ($urandom_range(0, 5)) put(any_but_lf());
        put(CH_LF);
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(0, 15)) begin
                if ($urandom_range(0, 99) < 85)
                    put(base_char());
                else if ($urandom_range(0, 1) == 0)
                    put(CH_SP);
                else
                    put(8'($urandom_range(9, 13)));
            end
            put(CH_LF);
        end
    endfunction

    initial
    begin
        int  recs;
        int  rand_start;
        int  r;
        int  cut;
        bit  in_fasta;
        bit  pressed;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        end_of_file = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: good FASTQ with CRs and a Solexa decision after a neutral byte
        put_line("@", 0);
        put_line("AC", 1);
        put_line("+", 0);
        put_line("JK", 1);
        // Sanger decision, quality line ended by end of file
        put_line("@", 0);
        put_line("AG", 0);
        put_line("+", 0);
        put(";");
        put(":");
        put_eof();
        // Error order: length over tag, tag over comment, then comment alone
        put_line("X", 0);
        put_line("A", 0);
        put_line("-", 0);
        put_line("!!", 0);
        put_line("X", 0);
        put_line("A", 0);
        put_line("-", 0);
        put_line("!", 0);
        put_line("@", 0);
        put_line("A", 0);
        put_line("", 0);
        put_line("!", 0);
        // FASTA closed by '>', then an empty FASTA body at end of file
        put_line(">", 0);
        put_line("A C", 0);
        put_line(">", 0);
        put_eof();
        // Truncated FASTA id, truncated FASTQ, bare end of file
        put(CH_GT);
        put_eof();
        put_line("@", 0);
        put("A");
        put_eof();
        put_eof();
        send_queued();

        // Random records
        recs       = 0;
        in_fasta   = 1'b0;
        pressed    = 1'b0;
        rand_start = sent_beats;
        while (sent_beats - rand_start < RANDOM_BEATS) begin
            if (recs % 20 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            // Hold the receiver off while the sender keeps streaming
            if (!pressed && sent_beats - rand_start >= PRESSURE_AT) begin
                pressed    = 1'b1;
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (in_fasta) begin
                if (r < 40) begin
                    put_eof();
                    in_fasta = 1'b0;
                end
                else begin
                    make_fasta();
                end
            end
            else if (r < 70) begin
                make_fastq();
            end
            else if (r < 85) begin
                make_fasta();
                in_fasta = 1'b1;
            end
            else if (r < 92) begin
                repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
                put_eof();
            end
            else begin
                put_eof();
            end
            // Cut some records short with an end of file
            if (beat_q.size() > 1 && !beat_q[$][8] && $urandom_range(0, 15) == 0) begin
                cut = $urandom_range(1, beat_q.size() - 1);
                while (beat_q.size() > cut)
                    void'(beat_q.pop_back());
                put_eof();
                in_fasta = 1'b0;
            end
            send_queued();
            recs++;
        end

        // Drain and settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fqfa_pkg.sv
rtl/fqfa_parser.sv
rtl/fqfa_result_queue.sv
rtl/fastq_fasta_record_parser_core.sv
verif/tb_top.sv
